>>> rtl/core/sgbe_pkg.sv
// ----------------------------------------------------------------------------
// sgbe_pkg
// shared types, constants and the character-to-glyph lookup of the scaled
// glyph block emitter
// ----------------------------------------------------------------------------
`default_nettype none

package sgbe_pkg;

  localparam int NUM_ROWS    = 7;
  localparam int NUM_COLS    = 5;
  localparam int NUM_GLYPHS  = 23;
  localparam int ROM_DEPTH   = NUM_GLYPHS * NUM_ROWS;
  localparam int ROM_AW      = $clog2(ROM_DEPTH);
  localparam int SCREEN_LIMIT = 4096;

  typedef logic [4:0] glyph_t;
  typedef logic [2:0] row_t;
  typedef logic [NUM_COLS-1:0] mask_t;

  localparam glyph_t GLYPH_BLANK = 5'd22;

  // glyph rom read request
  typedef struct packed {
    logic   en;
    glyph_t glyph;
    row_t   row;
  } rom_req_t;

  function automatic glyph_t glyph_index(input logic [7:0] code);
    glyph_t g;
    g = GLYPH_BLANK;
    if (code inside {["0":"9"]}) begin
      g = 5'(code - 8'h30);
    end else begin
      case (code)
        "T":     g = 5'd10;
        "I":     g = 5'd11;
        "M":     g = 5'd12;
        "E":     g = 5'd13;
        "F":     g = 5'd14;
        "P":     g = 5'd15;
        "S":     g = 5'd16;
        "K":     g = 5'd17;
        "L":     g = 5'd18;
        "O":     g = 5'd19;
        "R":     g = 5'd20;
        ":":     g = 5'd21;
        default: g = GLYPH_BLANK;
      endcase
    end
    return g;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/scaled_glyph_block_emitter_top.sv
// ----------------------------------------------------------------------------
// scaled_glyph_block_emitter_top
// turns one character request into clipped, scaled blocks of its lit glyph
// cells, one block per output transaction
// ----------------------------------------------------------------------------
//  channel | direction | carries
//  in_     | slave     | char code, signed origin, scale, colour
//  out_    | master    | clipped block position, size, colour; tlast on last
//  cfg_    | apb       | screen_width at 0x0, screen_height at 0x4
//
//  a character is accepted only in the idle state; the scan then walks all
//  cells of its 5x7 glyph (one glyph cell per cycle unless output back-pressure
//  stalls it, rows fetched from the font rom one row ahead) and a flush state
//  issues the final block; a scale of zero leaves the block idle with no transactions
//  output back-pressure stalls the scan or the flush only when the held block
//  has to move while the output register is full; synchronous active-low reset
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_glyph_block_emitter_top #(
  parameter int MAX_SCALE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // code[7:0] origin_x[20:8] origin_y[33:21] scale[37:34] red[45:38]
  // green[53:46] blue[61:54] zero[63:62]
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // block_x[11:0] block_y[23:12] block_w[27:24] block_h[31:28]
  // out_red[39:32] out_green[47:40] out_blue[55:48]
  output logic [55:0]      out_tdata,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  typedef logic signed [14:0] coord_t;
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FLUSH} state_t;

  localparam logic [2:0] LAST_COL = 3'(sgbe_pkg::NUM_COLS - 1);
  localparam logic [2:0] LAST_ROW = 3'(sgbe_pkg::NUM_ROWS - 1);
  localparam logic       REG_WIDTH  = 1'b0;
  localparam logic       REG_HEIGHT = 1'b1;

  state_t            state_r;
  logic [12:0]       cfg_w_r, cfg_h_r;
  logic [12:0]       scr_w_r, scr_h_r;
  sgbe_pkg::glyph_t  glyph_r;
  sgbe_pkg::row_t    row_r;
  logic [2:0]        col_r;
  logic [3:0]        scale_r;
  coord_t            ox_r, x_r, y_r;
  logic [7:0]        red_r, green_r, blue_r;
  logic              pend_v_r;
  logic [11:0]       pend_x_r, pend_y_r;
  logic [3:0]        pend_w_r, pend_h_r;
  logic [55:0]       out_data_r;
  logic              out_last_r, out_valid_r;

  sgbe_pkg::rom_req_t rom_req;
  sgbe_pkg::mask_t    rom_q;

  logic        in_xfer, cfg_wr;
  logic [3:0]  in_scale, eff_scale;
  coord_t      s_ext, x1, y1, sw_s, sh_s, cx0, cx1, cy0, cy1;
  logic        lit, vis, slot_free, advance, row_end;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_HEIGHT) ? {19'd0, cfg_h_r} : {19'd0, cfg_w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= 13'd640;
      cfg_h_r <= 13'd480;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_WIDTH) begin
        cfg_w_r <= cfg_pwdata[12:0];
      end else begin
        cfg_h_r <= cfg_pwdata[12:0];
      end
    end
  end

  // input side
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign in_scale  = in_tdata[37:34];
  assign eff_scale = (int'(in_scale) > MAX_SCALE) ? 4'(MAX_SCALE) : in_scale;

  // current cell geometry and clipping
  assign lit     = rom_q[LAST_COL - col_r];
  assign s_ext   = coord_t'({11'd0, scale_r});
  assign x1      = x_r + s_ext;
  assign y1      = y_r + s_ext;
  assign sw_s    = coord_t'({2'd0, scr_w_r});
  assign sh_s    = coord_t'({2'd0, scr_h_r});
  assign vis     = lit && (x_r < sw_s) && (y_r < sh_s) && (x1 > 0) && (y1 > 0);
  assign cx0     = (x_r < 0) ? '0 : x_r;
  assign cy0     = (y_r < 0) ? '0 : y_r;
  assign cx1     = (x1 > sw_s) ? sw_s : x1;
  assign cy1     = (y1 > sh_s) ? sh_s : y1;

  assign slot_free = !out_valid_r || out_tready;
  assign advance   = (state_r == S_SCAN) && (!vis || !pend_v_r || slot_free);
  assign row_end   = (col_r == LAST_COL);

  // font rom: first row at accept, next row on the last column of a row
  always_comb begin
    rom_req = '0;
    if (in_xfer) begin
      rom_req.en    = 1'b1;
      rom_req.glyph = sgbe_pkg::glyph_index(in_tdata[7:0]);
      rom_req.row   = '0;
    end else if (advance && row_end && (row_r != LAST_ROW)) begin
      rom_req.en    = 1'b1;
      rom_req.glyph = glyph_r;
      rom_req.row   = row_r + 3'd1;
    end
  end

  sgbe_font_rom u_rom (
    .clk (clk),
    .req (rom_req),
    .q   (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer && (eff_scale != 4'd0)) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (advance) begin
            if (vis) begin
              pend_v_r <= 1'b1;
              if (pend_v_r) begin
                out_valid_r <= 1'b1;
              end
            end
            if (row_end && (row_r == LAST_ROW)) begin
              state_r <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            pend_v_r    <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      glyph_r <= sgbe_pkg::glyph_index(in_tdata[7:0]);
      row_r   <= '0;
      col_r   <= '0;
      scale_r <= eff_scale;
      ox_r    <= coord_t'(signed'(in_tdata[20:8]));
      x_r     <= coord_t'(signed'(in_tdata[20:8]));
      y_r     <= coord_t'(signed'(in_tdata[33:21]));
      red_r   <= in_tdata[45:38];
      green_r <= in_tdata[53:46];
      blue_r  <= in_tdata[61:54];
      scr_w_r <= (int'(cfg_w_r) > sgbe_pkg::SCREEN_LIMIT) ?
                 13'(sgbe_pkg::SCREEN_LIMIT) : cfg_w_r;
      scr_h_r <= (int'(cfg_h_r) > sgbe_pkg::SCREEN_LIMIT) ?
                 13'(sgbe_pkg::SCREEN_LIMIT) : cfg_h_r;
    end else if (advance) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= row_r + 3'd1;
        x_r   <= ox_r;
        y_r   <= y1;
      end else begin
        col_r <= col_r + 3'd1;
        x_r   <= x1;
      end
    end

    if (advance && vis) begin
      pend_x_r <= cx0[11:0];
      pend_y_r <= cy0[11:0];
      pend_w_r <= 4'(cx1 - cx0);
      pend_h_r <= 4'(cy1 - cy0);
    end

    if ((advance && vis && pend_v_r) || ((state_r == S_FLUSH) && pend_v_r && slot_free)) begin
      out_data_r <= {blue_r, green_r, red_r, pend_h_r, pend_w_r, pend_y_r, pend_x_r};
      out_last_r <= (state_r == S_FLUSH);
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/core/sgbe_font_rom.sv
// ----------------------------------------------------------------------------
// sgbe_font_rom
// 5x7 font rom, one glyph row per entry, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module sgbe_font_rom (
  input  wire logic              clk,
  input  wire sgbe_pkg::rom_req_t req,
  output sgbe_pkg::mask_t        q
);

  localparam sgbe_pkg::mask_t FONT_ROM [sgbe_pkg::ROM_DEPTH] = '{
    5'h1E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h1E,
    5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F,
    5'h1E, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h10, 5'h1F,
    5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E,
    5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02,
    5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E,
    5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h1E,
    5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08,
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E,
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h01, 5'h01, 5'h0E,
    5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04,
    5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F,
    5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11,
    5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F,
    5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10,
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10,
    5'h0F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E,
    5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11,
    5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F,
    5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,
    5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11,
    5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00,
    5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00
  };

  logic [sgbe_pkg::ROM_AW-1:0] addr;
  sgbe_pkg::mask_t             q_r;

  assign addr = sgbe_pkg::ROM_AW'(req.glyph) * sgbe_pkg::ROM_AW'(sgbe_pkg::NUM_ROWS)
              + sgbe_pkg::ROM_AW'(req.row);

  always_ff @(posedge clk) begin
    if (req.en) begin
      q_r <= FONT_ROM[addr];
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

>>> rtl/core/sgbe_checker.sv
// ----------------------------------------------------------------------------
// sgbe_checker
// port-level checks of the scaled glyph block emitter
// ----------------------------------------------------------------------------
`default_nettype none

module sgbe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic [63:0] in_tdata,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic        cfg_pready
);

  // a stalled transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  // a request with nonzero scale starts a scan
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[37:34] != 4'd0) |=> !in_tready)
    else $error("input taken again before the scan of the last request");

  // a fresh block only comes out of a running scan or flush, never while idle
  a_out_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("block issued while idle");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("configuration port not ready");

endmodule

bind scaled_glyph_block_emitter_top sgbe_checker u_sgbe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tdata   (in_tdata),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

>>> dv/tb_scaled_glyph_block_emitter_top.sv
// ----------------------------------------------------------------------------
// tb_scaled_glyph_block_emitter_top
// self-checking bench for the scaled glyph block emitter: a directed set of
// characters and a long random stream across several screen sizes, each
// output transaction compared field by field against a local glyph predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scaled_glyph_block_emitter_top;

  localparam int MAX_SCALE = 8;
  localparam logic [2:0] REG_SCREEN_W = 3'h0;
  localparam logic [2:0] REG_SCREEN_H = 3'h4;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_BLOCKS = 400;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [3:0]  w;
    logic [3:0]  h;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        last;
  } block_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  // code[7:0] origin_x[20:8] origin_y[33:21] scale[37:34] red[45:38]
  // green[53:46] blue[61:54] zero[63:62]
  logic [63:0] in_tdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  // block_x[11:0] block_y[23:12] block_w[27:24] block_h[31:28]
  // out_red[39:32] out_green[47:40] out_blue[55:48]
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  logic [63:0] pending_chars[$];
  block_t      expected_blocks[$];
  int          screen_w = 640;
  int          screen_h = 480;
  int          bad_blocks = 0;
  int          blocks_seen = 0;
  bit          gaps_on = 1'b1;
  logic        in_fire = 1'b0;
  int          send_gap = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  bit          pressure_done = 1'b0;
  string       font_chars = "0123456789TIMEFPSKLOR:";

  scaled_glyph_block_emitter_top #(.MAX_SCALE(MAX_SCALE)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int font_slot(input logic [7:0] code);
    if (code >= "0" && code <= "9") return int'(code - "0");
    case (code)
      "T": return 10;
      "I": return 11;
      "M": return 12;
      "E": return 13;
      "F": return 14;
      "P": return 15;
      "S": return 16;
      "K": return 17;
      "L": return 18;
      "O": return 19;
      "R": return 20;
      ":": return 21;
      default: return -1;
    endcase
  endfunction

  // rows top to bottom, leftmost column in bit 4
  function automatic logic [4:0] glyph_row(input int slot, input int row);
    logic [34:0] rows;
    case (slot)
      0:  rows = {5'h1E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h1E};
      1:  rows = {5'h04, 5'h0C, 5'h14, 5'h04, 5'h04, 5'h04, 5'h1F};
      2:  rows = {5'h1E, 5'h01, 5'h01, 5'h1E, 5'h10, 5'h10, 5'h1F};
      3:  rows = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
      4:  rows = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
      5:  rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      6:  rows = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h1E};
      7:  rows = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
      8:  rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
      9:  rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h01, 5'h01, 5'h0E};
      10: rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
      11: rows = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
      12: rows = {5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11};
      13: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
      14: rows = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
      15: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
      16: rows = {5'h0F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
      17: rows = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
      18: rows = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
      19: rows = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
      20: rows = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
      21: rows = {5'h00, 5'h04, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
      default: rows = '0;
    endcase
    return rows[34 - 5 * row -: 5];
  endfunction

  function automatic logic [63:0] pack_char(input logic [7:0] code, input int ox, input int oy,
                                            input int scale, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b);
    return {2'b00, b, g, r, 4'(scale), 13'(oy), 13'(ox), code};
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [63:0] random_char(input int w, input int h);
    int pick, lim_w, lim_h, ox, oy, scale;
    logic [7:0] code;
    lim_w = (w > sgbe_pkg::SCREEN_LIMIT) ? sgbe_pkg::SCREEN_LIMIT : w;
    lim_h = (h > sgbe_pkg::SCREEN_LIMIT) ? sgbe_pkg::SCREEN_LIMIT : h;
    pick = $urandom_range(0, 99);
    if (pick < 75) code = font_chars[$urandom_range(0, 21)];
    else if (pick < 82) code = "-";
    else if (pick < 88) code = 8'($urandom_range(32, 127));
    else code = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 85) scale = $urandom_range(1, MAX_SCALE);
    else if (pick < 95) scale = $urandom_range(MAX_SCALE + 1, 15);
    else scale = 0;
    if ($urandom_range(0, 99) < 75) begin
      ox = int'($urandom_range(0, lim_w + 60)) - 50;
      oy = int'($urandom_range(0, lim_h + 70)) - 60;
    end else begin
      ox = $urandom;
      oy = $urandom;
    end
    return pack_char(code, ox, oy, scale, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  task automatic predict_glyph_blocks(input logic [63:0] word);
    int slot, ox, oy, s, sw, sh, row, col, x0, y0, x1, y1;
    logic [4:0] lit;
    block_t blk, held;
    bit have_held;
    have_held = 1'b0;
    slot = font_slot(word[7:0]);
    ox = $signed(word[20:8]);
    oy = $signed(word[33:21]);
    s = word[37:34];
    if (s > MAX_SCALE) s = MAX_SCALE;
    sw = (screen_w > sgbe_pkg::SCREEN_LIMIT) ? sgbe_pkg::SCREEN_LIMIT : screen_w;
    sh = (screen_h > sgbe_pkg::SCREEN_LIMIT) ? sgbe_pkg::SCREEN_LIMIT : screen_h;
    if (slot < 0 || s == 0) return;
    for (row = 0; row < 7; row++) begin
      lit = glyph_row(slot, row);
      for (col = 0; col < 5; col++) begin
        if (!lit[4 - col]) continue;
        x0 = ox + col * s;
        y0 = oy + row * s;
        x1 = x0 + s;
        y1 = y0 + s;
        if (x0 >= sw || y0 >= sh || x1 <= 0 || y1 <= 0) continue;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > sw) x1 = sw;
        if (y1 > sh) y1 = sh;
        blk.x = 12'(x0);
        blk.y = 12'(y0);
        blk.w = 4'(x1 - x0);
        blk.h = 4'(y1 - y0);
        blk.red = word[45:38];
        blk.green = word[53:46];
        blk.blue = word[61:54];
        blk.last = 1'b0;
        if (have_held) expected_blocks.push_back(held);
        held = blk;
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      expected_blocks.push_back(held);
    end
  endtask

  task automatic check_block();
    block_t got, want;
    got = {out_tdata[11:0], out_tdata[23:12], out_tdata[27:24], out_tdata[31:28],
           out_tdata[39:32], out_tdata[47:40], out_tdata[55:48], out_tlast};
    blocks_seen++;
    if (expected_blocks.size() == 0) begin
      bad_blocks++;
      if (bad_blocks <= 10)
        $display("unexpected block x=%0d y=%0d w=%0d h=%0d rgb=%0d/%0d/%0d last=%0d",
                 got.x, got.y, got.w, got.h, got.red, got.green, got.blue, got.last);
      return;
    end
    want = expected_blocks.pop_front();
    if (got !== want) begin
      bad_blocks++;
      if (bad_blocks <= 10) begin
        $display("block mismatch at %0t", $realtime);
        $display("  expected x=%0d y=%0d w=%0d h=%0d rgb=%0d/%0d/%0d last=%0d",
                 want.x, want.y, want.w, want.h, want.red, want.green, want.blue, want.last);
        $display("  actual   x=%0d y=%0d w=%0d h=%0d rgb=%0d/%0d/%0d last=%0d",
                 got.x, got.y, got.w, got.h, got.red, got.green, got.blue, got.last);
      end
    end
  endtask

  // sampling side
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) predict_glyph_blocks(in_tdata);
    if (rst_n && out_tvalid && out_tready) check_block();
  end

  // character request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (send_gap > 0) begin
        in_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_chars.size() > 0) begin
        in_tdata <= pending_chars.pop_front();
        in_tvalid <= 1'b1;
        if (gaps_on) send_gap <= draw_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // block receiver, with one long hold-off to back the block up
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (!pressure_done && blocks_seen >= HOLD_AFTER_BLOCKS) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (gaps_on) stall_left <= draw_gap();
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_chars.size() != 0 || in_tvalid || expected_blocks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [12:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= 32'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    if (addr == REG_SCREEN_W) screen_w = value;
    else screen_h = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_phase(input int w, input int h, input int count, input bit gaps);
    wait_idle();
    gaps_on = gaps;
    cfg_write(REG_SCREEN_W, 13'(w));
    cfg_write(REG_SCREEN_H, 13'(h));
    repeat (count) pending_chars.push_back(random_char(w, h));
  endtask

  task automatic add_char(input logic [7:0] code, input int ox, input int oy, input int scale);
    pending_chars.push_back(pack_char(code, ox, oy, scale, 8'($urandom), 8'($urandom),
                                      8'($urandom)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset screen 640x480
    pending_chars.push_back(pack_char("0", 0, 0, 1, 8'h00, 8'h00, 8'h00));
    pending_chars.push_back(pack_char("1", 10, 10, 8, 8'hFF, 8'hFF, 8'hFF));
    add_char("2", -4096, -4096, 3);
    add_char("3", 4095, 4095, 2);
    add_char("4", -3, -5, 4);
    add_char("5", 630, 470, 3);
    add_char("6", 636, 20, 8);
    add_char("7", -20, 100, 5);
    add_char("8", 300, -30, 6);
    add_char("9", 200, 200, 15);
    add_char("T", 50, 50, 9);
    add_char("I", 0, 474, 1);
    add_char("M", 639, 479, 7);
    add_char("E", -39, -55, 8);
    add_char("F", 100, 100, 2);
    add_char("P", 400, 300, 4);
    add_char("S", 8, 8, 5);
    add_char("K", 20, 400, 8);
    add_char("L", 600, 430, 6);
    add_char("O", 1, 1, 1);
    add_char("R", 500, 50, 3);
    add_char(":", 320, 240, 8);
    add_char("-", 10, 10, 4);
    add_char(8'hFF, 10, 10, 4);
    add_char(8'h80, 0, 0, 8);
    add_char("8", 10, 10, 0);

    repeat (130) pending_chars.push_back(random_char(screen_w, screen_h));

    run_phase(4096, 4096, 60, 1'b0);
    run_phase(1, 1, 30, 1'b1);
    run_phase(8191, 8191, 40, 1'b1);
    run_phase(0, 480, 15, 1'b1);
    run_phase(640, 0, 15, 1'b1);
    repeat (3) run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 40, 1'b1);
    run_phase(13, 9, 30, 1'b1);
    wait_idle();

    if (bad_blocks == 0) begin
      $display("scaled_glyph_block_emitter_top verification clean");
    end else begin
      $display("scaled_glyph_block_emitter_top verification failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("scaled_glyph_block_emitter_top verification failed");
    $finish;
  end

endmodule
